@@ hw/rtl/stream_mode_finder_unit_assert.svh @@
// ----------------------------------------------------------------------------
// stream mode finder assertion macros
// shared concurrent assertion forms, all reset-qualified
// ----------------------------------------------------------------------------
`ifndef STREAM_MODE_FINDER_UNIT_ASSERT_SVH
`define STREAM_MODE_FINDER_UNIT_ASSERT_SVH

// condition must hold at every edge out of reset
`define SMF_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define SMF_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SMF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/smf_pkg.sv @@
// ----------------------------------------------------------------------------
// smf_pkg
// widths, queue sizing and shared types of the stream mode finder
// ----------------------------------------------------------------------------
`default_nettype none

package smf_pkg;

  localparam int VALUE_W     = 14;
  localparam int COUNT_W     = 17;
  localparam int COUNT_MAX   = 131071;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  // classified word passed from front to back
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               in_range;
    logic               last;
  } cls_word_t;

  // queue fill status
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

`default_nettype wire

@@ hw/rtl/smf_in_if.sv @@
// ----------------------------------------------------------------------------
// smf_in_if
// sample channel: valid/ready handshake with one data set element per word
// ----------------------------------------------------------------------------
`default_nettype none

interface smf_in_if;
  import smf_pkg::*;

  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] sample_value;
  logic               last_item;

  modport source (output valid, output sample_value, output last_item, input ready);
  modport sink   (input valid, input sample_value, input last_item, output ready);

endinterface

`default_nettype wire

@@ hw/rtl/smf_out_if.sv @@
// ----------------------------------------------------------------------------
// smf_out_if
// result channel: valid/ready handshake carrying mode value and count
// ----------------------------------------------------------------------------
`default_nettype none

interface smf_out_if;
  import smf_pkg::*;

  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] mode_value;
  logic [COUNT_W-1:0] mode_count;

  modport source (output valid, output mode_value, output mode_count, input ready);
  modport sink   (input valid, input mode_value, input mode_count, output ready);

endinterface

`default_nettype wire

@@ hw/rtl/stream_mode_finder_unit.sv @@
// ----------------------------------------------------------------------------
// stream_mode_finder_unit: mode of each data set, smallest value on ties
// one word per cycle within a set while the queue has room; the result is registered;
// after rst (synchronous) and each set end a sweep of min(VALUE_RANGE, 16384)
// entries zeroes the histogram, in_ch.ready low; the histogram port sets the rate
// ----------------------------------------------------------------------------
`default_nettype none

module stream_mode_finder_unit #(
  parameter int VALUE_RANGE   = 16384,
  parameter int MAX_SET_ITEMS = 131071
) (
  input  wire        clk,
  input  wire        rst,
  smf_in_if.sink     in_ch,
  smf_out_if.source  out_ch
);
  import smf_pkg::*;

  logic      push;
  cls_word_t push_word;
  logic      pop;
  cls_word_t q_word;
  q_status_t q_stat;
  logic      clearing;

  // classify front
  smf_front #(
    .VALUE_RANGE (VALUE_RANGE)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .clearing  (clearing),
    .q_stat    (q_stat),
    .push      (push),
    .push_word (push_word)
  );

  // decoupling queue
  smf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_word (push_word),
    .pop       (pop),
    .q_word    (q_word),
    .q_stat    (q_stat)
  );

  // histogram back
  smf_back #(
    .VALUE_RANGE   (VALUE_RANGE),
    .MAX_SET_ITEMS (MAX_SET_ITEMS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_word   (q_word),
    .q_stat   (q_stat),
    .pop      (pop),
    .clearing (clearing),
    .out_ch   (out_ch)
  );

endmodule

`default_nettype wire

@@ hw/rtl/smf_front.sv @@
// ----------------------------------------------------------------------------
// smf_front
// accepts sample words, classifies them against the value range and
// hands them to the queue through a single register stage
// ----------------------------------------------------------------------------
`default_nettype none

module smf_front #(
  parameter int VALUE_RANGE = 16384
) (
  input  wire                  clk,
  input  wire                  rst,
  smf_in_if.sink               in_ch,
  input  wire                  clearing,
  input  smf_pkg::q_status_t   q_stat,
  output logic                 push,
  output smf_pkg::cls_word_t   push_word
);
  import smf_pkg::*;

  logic      f_valid;
  cls_word_t f_word;
  logic      take;
  logic      in_range;

  // hold off while the histogram sweep runs or the stage cannot drain
  assign in_ch.ready = !clearing && (!f_valid || !q_stat.full);
  assign take        = in_ch.valid && in_ch.ready;
  assign push        = f_valid && !q_stat.full;
  assign push_word   = f_word;

  // values at or above the range are carried but not counted
  assign in_range = (32'(in_ch.sample_value) < 32'(VALUE_RANGE));

  // classify stage
  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (take) begin
      f_valid <= 1'b1;
    end else if (push) begin
      f_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      f_word.value    <= in_ch.sample_value;
      f_word.in_range <= in_range;
      f_word.last     <= in_ch.last_item;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/smf_queue.sv @@
// ----------------------------------------------------------------------------
// smf_queue
// small flop fifo decoupling the classify front from the histogram back
// ----------------------------------------------------------------------------
`default_nettype none

`include "stream_mode_finder_unit_assert.svh"

module smf_queue (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  push,
  input  smf_pkg::cls_word_t   push_word,
  input  wire                  pop,
  output smf_pkg::cls_word_t   q_word,
  output smf_pkg::q_status_t   q_stat
);
  import smf_pkg::*;

  cls_word_t         slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] cnt;

  assign q_word       = slots[rd_ptr];
  assign q_stat.full  = (cnt == QCNT_W'(QUEUE_DEPTH));
  assign q_stat.empty = (cnt == '0);

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_word;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
    end
  end

  `SMF_ASSERT_IMPLY(a_push_not_full, clk, rst, push, !q_stat.full, "push into full queue")
  `SMF_ASSERT_IMPLY(a_pop_not_empty, clk, rst, pop, !q_stat.empty, "pop from empty queue")

endmodule

`default_nettype wire

@@ hw/rtl/smf_back.sv @@
// ----------------------------------------------------------------------------
// smf_back
// histogram read-modify-write with forwarding, running best, result register
// and the zeroing sweep between sets
// ----------------------------------------------------------------------------
`default_nettype none

`include "stream_mode_finder_unit_assert.svh"

module smf_back #(
  parameter int VALUE_RANGE   = 16384,
  parameter int MAX_SET_ITEMS = 131071
) (
  input  wire                  clk,
  input  wire                  rst,
  input  smf_pkg::cls_word_t   q_word,
  input  smf_pkg::q_status_t   q_stat,
  output logic                 pop,
  output logic                 clearing,
  smf_out_if.source            out_ch
);
  import smf_pkg::*;

  localparam int DEPTH     = (VALUE_RANGE < (1 << VALUE_W)) ? VALUE_RANGE : (1 << VALUE_W);
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int LIMIT_INT = (MAX_SET_ITEMS < COUNT_MAX) ? MAX_SET_ITEMS : COUNT_MAX;
  localparam logic [COUNT_W-1:0] LIMIT = COUNT_W'(LIMIT_INT);

  typedef enum logic {
    ST_RUN,
    ST_CLEAR
  } state_t;

  state_t             state;
  logic [ADDR_W-1:0]  clr_cnt;

  logic [COUNT_W-1:0] hist [DEPTH];
  logic [COUNT_W-1:0] rdata;
  logic [ADDR_W-1:0]  rd_addr;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [COUNT_W-1:0] mem_wdata;

  logic               b_valid;
  logic [VALUE_W-1:0] b_value;
  logic               b_in_range;
  logic               b_last;
  logic [ADDR_W-1:0]  b_addr;

  logic               fwd_valid;
  logic [ADDR_W-1:0]  fwd_addr;
  logic [COUNT_W-1:0] fwd_data;

  logic [COUNT_W-1:0] cur;
  logic [COUNT_W-1:0] inc;
  logic               take_best;

  logic [VALUE_W-1:0] best_value;
  logic [COUNT_W-1:0] best_count;
  logic [VALUE_W-1:0] best_value_next;
  logic [COUNT_W-1:0] best_count_next;

  logic               out_valid;
  logic [VALUE_W-1:0] out_value;
  logic [COUNT_W-1:0] out_count;

  assign clearing = (state == ST_CLEAR);

  // pop one word a cycle; a last word waits for a free result register
  // and nothing follows it until the sweep is done
  assign pop = (state == ST_RUN) && !q_stat.empty && !(b_valid && b_last) &&
               (!q_word.last || !out_valid);

  assign rd_addr = q_word.value[ADDR_W-1:0];
  assign b_addr  = b_value[ADDR_W-1:0];

  // count update with forwarding of the previous write
  always_comb begin
    cur = (fwd_valid && (fwd_addr == b_addr)) ? fwd_data : rdata;
    inc = (cur < LIMIT) ? cur + 1'b1 : cur;
    take_best = b_valid && b_in_range &&
                ((inc > best_count) || ((inc == best_count) && (b_value < best_value)));
    best_value_next = take_best ? b_value : best_value;
    best_count_next = take_best ? inc : best_count;
  end

  // histogram write source: sweep or update
  always_comb begin
    if (state == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt;
      mem_wdata = '0;
    end else begin
      mem_we    = b_valid && b_in_range;
      mem_waddr = b_addr;
      mem_wdata = inc;
    end
  end

  // histogram memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      hist[mem_waddr] <= mem_wdata;
    end
    rdata <= hist[rd_addr];
  end

  // update stage word
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      b_value    <= q_word.value;
      b_in_range <= q_word.in_range;
      b_last     <= q_word.last;
    end
  end

  // forwarding register
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else begin
      fwd_valid <= (state == ST_RUN) && b_valid && b_in_range;
    end
  end

  always_ff @(posedge clk) begin
    fwd_addr <= b_addr;
    fwd_data <= inc;
  end

  // control: state, sweep counter, best and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_cnt    <= '0;
      best_value <= '0;
      best_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_RUN: begin
          if (b_valid && b_last) begin
            out_valid  <= 1'b1;
            out_value  <= best_value_next;
            out_count  <= best_count_next;
            best_value <= '0;
            best_count <= '0;
            clr_cnt    <= '0;
            state      <= ST_CLEAR;
          end else begin
            best_value <= best_value_next;
            best_count <= best_count_next;
          end
        end
        ST_CLEAR: begin
          if (clr_cnt == ADDR_W'(DEPTH - 1)) begin
            state <= ST_RUN;
          end
          clr_cnt <= clr_cnt + 1'b1;
        end
        default: begin
          state <= ST_CLEAR;
        end
      endcase
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.mode_value = out_value;
  assign out_ch.mode_count = out_count;

  `SMF_ASSERT_IMPLY(a_no_pop_in_sweep, clk, rst, state == ST_CLEAR, !pop, "pop during sweep")
  `SMF_ASSERT_IMPLY(a_result_slot_free, clk, rst, b_valid && b_last, !out_valid,
                    "set end with result register busy")
  `SMF_ASSERT_ALWAYS(a_best_in_limit, clk, rst, best_count <= LIMIT, "best count over limit")
  `SMF_ASSERT_NEXT(a_set_end_resets, clk, rst, b_valid && b_last,
                   (state == ST_CLEAR) && (best_count == '0) && out_valid,
                   "set end did not start sweep")

endmodule

`default_nettype wire

@@ dv/stream_mode_finder_unit_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stream_mode_finder_unit_tb
// self-checking bench for the stream mode finder: a histogram model predicts
// the mode (smallest value on ties) and its saturating count for every data
// set; directed sets, an output hold-off and random sets are driven through
// bursty input and a stalling result channel
// ----------------------------------------------------------------------------

module stream_mode_finder_unit_tb;
  import smf_pkg::*;

  localparam int          SET_VALUE_RANGE = 16384;
  localparam int          SET_MAX_ITEMS   = 131071;
  localparam int unsigned COUNT_CAP       = (SET_MAX_ITEMS < COUNT_MAX) ?
                                            SET_MAX_ITEMS : COUNT_MAX;
  localparam int          RANDOM_ITEMS    = 1520;
  localparam int          RANDOM_SETS_MIN = 24;
  localparam int          HOLDOFF_CYCLES  = 120000;
  localparam int          DRAIN_LIMIT     = 200000;
  localparam int          CYCLE_LIMIT     = 100000000;

  typedef enum logic { RX_STEADY, RX_CHOPPY } rx_style_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [COUNT_W-1:0] count;
  } mode_result_t;

  logic clk = 1'b0;
  logic rst;

  smf_in_if  in_ch();
  smf_out_if out_ch();

  stream_mode_finder_unit #(
    .VALUE_RANGE  (SET_VALUE_RANGE),
    .MAX_SET_ITEMS(SET_MAX_ITEMS)
  ) u_dut (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // histogram model and its running leader
  int unsigned  occ_count [SET_VALUE_RANGE];
  int unsigned  lead_value;
  int unsigned  lead_count;
  mode_result_t expected_modes[$];

  int        mismatch_count = 0;
  int        cycle_count    = 0;
  int        burst_left     = 0;
  bit        gaps_on        = 1'b1;
  int        holdoff_left   = 0;
  rx_style_t rx_style       = RX_STEADY;

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: run limit of %0d cycles reached", $time, CYCLE_LIMIT);
      $display("** stream_mode_finder_unit: FAILED **");
      $finish;
    end
  end

  function automatic void clear_histogram();
    foreach (occ_count[i]) occ_count[i] = 0;
    lead_value = 0;
    lead_count = 0;
  endfunction

  // model update for one accepted word, queues the mode on the last word
  function automatic void update_histogram(input logic [VALUE_W-1:0] value,
                                           input logic is_last);
    int unsigned idx;
    int unsigned cnt;
    mode_result_t res;
    idx = 32'(value);
    if (idx < SET_VALUE_RANGE) begin
      cnt = occ_count[idx];
      if (cnt < COUNT_CAP) cnt++;
      occ_count[idx] = cnt;
      if (cnt > lead_count || (cnt == lead_count && idx < lead_value)) begin
        lead_count = cnt;
        lead_value = idx;
      end
    end
    if (is_last) begin
      res.value = lead_value[VALUE_W-1:0];
      res.count = lead_count[COUNT_W-1:0];
      expected_modes.push_back(res);
      clear_histogram();
    end
  endfunction

  // one word on the sample channel, with burst gaps when enabled
  task automatic send_word(input logic [VALUE_W-1:0] value, input logic is_last);
    if (gaps_on && burst_left == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 16);
    end
    in_ch.valid        = 1'b1;
    in_ch.sample_value = value;
    in_ch.last_item    = is_last;
    do @(posedge clk); while (!in_ch.ready);
    update_histogram(value, is_last);
    if (burst_left > 0) burst_left--;
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  task automatic send_set(input int unsigned words[$]);
    foreach (words[i]) send_word(words[i][VALUE_W-1:0], i == words.size() - 1);
  endtask

  // sender pause until every queued mode has left the block or DRAIN_LIMIT runs out
  task automatic wait_modes_drained();
    int waited;
    waited = 0;
    while (expected_modes.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
  endtask

  // result channel receiver: steady, choppy runs, or a counted hold-off
  initial begin : result_receiver
    int   run_left;
    logic ready_now;
    run_left     = 0;
    ready_now    = 1'b1;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (holdoff_left > 0) begin
        out_ch.ready = 1'b0;
        holdoff_left--;
      end else if (rx_style == RX_STEADY) begin
        out_ch.ready = 1'b1;
      end else begin
        if (run_left == 0) begin
          ready_now = ~ready_now;
          run_left  = ready_now ? $urandom_range(1, 8) : $urandom_range(1, 5);
        end
        run_left--;
        out_ch.ready = ready_now;
      end
    end
  end

  // compare each accepted result word with the oldest queued mode
  always @(posedge clk) begin : result_check
    mode_result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_modes.size() == 0) begin
        $display("%0t: result with none expected, value %0d count %0d", $time,
                 out_ch.mode_value, out_ch.mode_count);
        mismatch_count++;
      end else begin
        want = expected_modes.pop_front();
        if (out_ch.mode_value !== want.value) begin
          $display("%0t: mode_value expected %0d actual %0d", $time,
                   want.value, out_ch.mode_value);
          mismatch_count++;
        end
        if (out_ch.mode_count !== want.count) begin
          $display("%0t: mode_count expected %0d actual %0d", $time,
                   want.count, out_ch.mode_count);
          mismatch_count++;
        end
      end
    end
  end

  // field extremes, one-word sets and a set of one repeated value
  task automatic test_single_word_sets();
    int unsigned words[$];
    words = '{16383};
    send_set(words);
    words = '{0};
    send_set(words);
    words = '{8191};
    send_set(words);
    words = '{42, 42, 42, 42};
    send_set(words);
  endtask

  // ties go to the smaller value, a higher count beats a smaller value
  task automatic test_tie_breaks();
    int unsigned words[$];
    rx_style = RX_CHOPPY;
    words = '{500, 20, 500, 20, 9000};
    send_set(words);
    words = '{16383, 0, 16383, 8191};
    send_set(words);
    words = '{3, 3, 1, 1, 2, 2};
    send_set(words);
    rx_style = RX_STEADY;
  endtask

  // long receiver hold-off while sets keep arriving, then a full drain
  task automatic test_output_holdoff();
    holdoff_left = HOLDOFF_CYCLES;
    for (int i = 0; i < 7; i++) send_word(VALUE_W'($urandom_range(0, 16383)), 1'b1);
    wait_modes_drained();
  endtask

  // random sets: mostly narrow value pools for ties, some full range
  task automatic test_random_sets();
    int          items_sent;
    int          sets_done;
    int          set_len;
    int unsigned span;
    int unsigned base;
    bit          full_range;
    logic [VALUE_W-1:0] value;
    items_sent = 0;
    sets_done  = 0;
    while (items_sent < RANDOM_ITEMS || sets_done < RANDOM_SETS_MIN) begin
      rx_style   = ($urandom_range(0, 2) == 0) ? RX_STEADY : RX_CHOPPY;
      gaps_on    = ($urandom_range(0, 4) != 0);
      set_len    = ($urandom_range(0, 7) == 0) ? $urandom_range(150, 250) :
                                                 $urandom_range(1, 100);
      full_range = ($urandom_range(0, 3) == 0);
      span       = $urandom_range(1, 10);
      base       = $urandom_range(0, 16383 - span);
      for (int i = 0; i < set_len; i++) begin
        if (full_range) value = VALUE_W'($urandom_range(0, 16383));
        else value = VALUE_W'(base + $urandom_range(0, span));
        send_word(value, i == set_len - 1);
      end
      items_sent += set_len;
      sets_done++;
    end
    gaps_on  = 1'b1;
    rx_style = RX_STEADY;
  endtask

  initial begin
    rst                = 1'b1;
    in_ch.valid        = 1'b0;
    in_ch.sample_value = '0;
    in_ch.last_item    = 1'b0;
    clear_histogram();
    repeat (8) @(negedge clk);
    rst = 1'b0;

    test_single_word_sets();
    test_tie_breaks();
    test_output_holdoff();
    test_random_sets();

    // final drain and settle
    wait_modes_drained();
    if (expected_modes.size() != 0) begin
      $display("%0t: %0d modes never arrived", $time, expected_modes.size());
      mismatch_count += expected_modes.size();
    end
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("** stream_mode_finder_unit: PASSED **");
    end else begin
      $display("** stream_mode_finder_unit: FAILED **");
    end
    $finish;
  end

endmodule
